FILE: rtl/core/host_command_frame_parser_top_macros.svh
// ---------------------------------------------------------------------------
// Host command frame parser assertion macros
// Shared property forms for the checker; clk and arst_n come from the scope.
// ---------------------------------------------------------------------------
`ifndef HOST_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define HOST_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

// consequent must hold in the same cycle
`define HCFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent must hold in the following cycle
`define HCFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/core/hcfp_pkg.sv
// ---------------------------------------------------------------------------
// Host command frame parser package
// Command and error codes, register indexes, character constants and the
// types shared by the parser core and the top level.
// ---------------------------------------------------------------------------
package hcfp_pkg;

	typedef enum logic [2:0] {
		CMD_SEND  = 3'd0,
		CMD_ROUTE = 3'd1,
		CMD_CHECK = 3'd2,
		CMD_TEST  = 3'd3,
		CMD_NONE  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_LEN     = 3'd1,
		ERR_DEST    = 3'd2,
		ERR_DIR     = 3'd3,
		ERR_FLAG    = 3'd4,
		ERR_UNKNOWN = 3'd5,
		ERR_FORMAT  = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		CFG_OPTION_FLAG = 2'd0,
		CFG_PEER        = 2'd1,
		CFG_BROADCAST   = 2'd2
	} cfg_idx_t;

	localparam logic [7:0] OPTION_FLAG_RST = 8'd68;
	localparam logic [7:0] PEER_RST        = 8'd80;
	localparam logic [7:0] BROADCAST_RST   = 8'd66;

	localparam logic [7:0] LEN_OFFSET    = 8'd32;
	localparam logic [7:0] PAYLOAD_START = 8'd7;
	localparam logic [7:0] POS_MAX       = 8'hff;

	localparam logic [7:0] CH_A_LOWER = 8'h61;
	localparam logic [7:0] CH_Z_LOWER = 8'h7a;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_Z       = 8'h5a;
	localparam logic [7:0] CH_T       = 8'h54;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_N       = 8'h4e;

	localparam logic [8:0] DEST_PEER      = 9'h100;
	localparam logic [8:0] DEST_BROADCAST = 9'h0ff;

	typedef struct packed {
		logic [7:0] option_flag;
		logic [7:0] peer;
		logic [7:0] broadcast;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload;
		cmd_t        command;
		err_t        error;
		logic [8:0]  dest;
		logic [7:0]  msg_len;
		logic [15:0] group_count;
		logic [15:0] fail_delay;
	} res_t;

endpackage

FILE: rtl/core/hcfp_core.sv
// ---------------------------------------------------------------------------
// Host command frame parser core
// Running frame state and the per-byte parse step; produces at most one
// result per byte and clears itself on the end beat.
// ---------------------------------------------------------------------------
module hcfp_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      frame_byte,
	input  logic            frame_end,
	input  hcfp_pkg::cfg_t  cfg,
	output logic            res_valid,
	output hcfp_pkg::res_t  res
);

	logic [7:0]     pos_q, pos_d;
	logic [7:0]     decl_q, decl_d;
	logic [7:0]     letter_q, letter_d;
	hcfp_pkg::cmd_t cmd_q, cmd_d;
	hcfp_pkg::err_t ferr_q, ferr_d;
	logic [8:0]     dest_q, dest_d;
	logic [15:0]    num1_q, num1_d;
	logic [15:0]    num2_q, num2_d;
	logic           comma_q, comma_d;
	logic [15:0]    acc_src, acc_val;
	hcfp_pkg::err_t verdict;

	assign acc_src = comma_q ? num2_q : num1_q;
	assign acc_val = (acc_src << 3) + (acc_src << 1) + {8'd0, frame_byte}
		- {8'd0, hcfp_pkg::CH_ZERO};

	always_comb begin
		if (pos_q == 8'd0 || pos_q != decl_q) begin
			verdict = hcfp_pkg::ERR_LEN;
		end else if (ferr_q != hcfp_pkg::ERR_OK) begin
			verdict = ferr_q;
		end else if (cmd_q == hcfp_pkg::CMD_NONE) begin
			verdict = hcfp_pkg::ERR_UNKNOWN;
		end else if (cmd_q == hcfp_pkg::CMD_SEND && decl_q < hcfp_pkg::PAYLOAD_START) begin
			verdict = hcfp_pkg::ERR_FORMAT;
		end else if (cmd_q == hcfp_pkg::CMD_TEST && !comma_q) begin
			verdict = hcfp_pkg::ERR_FORMAT;
		end else begin
			verdict = hcfp_pkg::ERR_OK;
		end
	end

	always_comb begin
		pos_d     = (pos_q == hcfp_pkg::POS_MAX) ? pos_q : pos_q + 8'd1;
		decl_d    = decl_q;
		letter_d  = letter_q;
		cmd_d     = cmd_q;
		ferr_d    = ferr_q;
		dest_d    = dest_q;
		num1_d    = num1_q;
		num2_d    = num2_q;
		comma_d   = comma_q;
		res_valid = 1'b0;
		res       = '0;
		res.command = hcfp_pkg::CMD_SEND;
		res.error   = hcfp_pkg::ERR_OK;

		if (frame_end) begin
			res_valid   = 1'b1;
			res.kind    = 1'b1;
			res.error   = verdict;
			res.command = (verdict == hcfp_pkg::ERR_OK) ? cmd_q : hcfp_pkg::CMD_NONE;
			if (verdict == hcfp_pkg::ERR_OK && cmd_q == hcfp_pkg::CMD_SEND) begin
				res.dest    = dest_q;
				res.msg_len = decl_q - hcfp_pkg::PAYLOAD_START;
			end
			if (verdict == hcfp_pkg::ERR_OK && cmd_q == hcfp_pkg::CMD_TEST) begin
				res.group_count = num1_q;
				res.fail_delay  = num2_q;
			end
			pos_d    = '0;
			decl_d   = '0;
			letter_d = '0;
			cmd_d    = hcfp_pkg::CMD_NONE;
			ferr_d   = hcfp_pkg::ERR_OK;
			dest_d   = '0;
			num1_d   = '0;
			num2_d   = '0;
			comma_d  = 1'b0;
		end else if (pos_q == 8'd0) begin
			decl_d = (frame_byte >= hcfp_pkg::LEN_OFFSET) ?
				frame_byte - hcfp_pkg::LEN_OFFSET : 8'd0;
		end else if (pos_q == 8'd1) begin
			letter_d = frame_byte;
		end else if (pos_q == 8'd2) begin
			if (letter_q == hcfp_pkg::CH_S && frame_byte == hcfp_pkg::CH_Z) begin
				cmd_d = hcfp_pkg::CMD_SEND;
			end else if (letter_q == hcfp_pkg::CH_Z && frame_byte == hcfp_pkg::CH_T) begin
				cmd_d = hcfp_pkg::CMD_ROUTE;
			end else if (letter_q == hcfp_pkg::CH_S && frame_byte == hcfp_pkg::CH_C) begin
				cmd_d = hcfp_pkg::CMD_CHECK;
			end else if (letter_q == hcfp_pkg::CH_T && frame_byte == hcfp_pkg::CH_N) begin
				cmd_d = hcfp_pkg::CMD_TEST;
			end else begin
				cmd_d = hcfp_pkg::CMD_NONE;
				if (ferr_q == hcfp_pkg::ERR_OK) begin
					ferr_d = hcfp_pkg::ERR_UNKNOWN;
				end
			end
		end else if (cmd_q == hcfp_pkg::CMD_SEND && ferr_q == hcfp_pkg::ERR_OK) begin
			if (pos_q == 8'd3) begin
				if (frame_byte != cfg.option_flag) begin
					ferr_d = hcfp_pkg::ERR_FLAG;
				end
			end else if (pos_q == 8'd4) begin
				if (frame_byte == cfg.peer) begin
					dest_d = hcfp_pkg::DEST_PEER;
				end else if (frame_byte == cfg.broadcast) begin
					dest_d = hcfp_pkg::DEST_BROADCAST;
				end else begin
					ferr_d = hcfp_pkg::ERR_DIR;
				end
			end else if (pos_q == 8'd5) begin
				if (dest_q == hcfp_pkg::DEST_PEER) begin
					if (frame_byte >= hcfp_pkg::CH_A_LOWER &&
						frame_byte <= hcfp_pkg::CH_Z_LOWER) begin
						dest_d = hcfp_pkg::DEST_PEER +
							{1'b0, frame_byte - hcfp_pkg::CH_A_LOWER};
					end else begin
						ferr_d = hcfp_pkg::ERR_DEST;
					end
				end
			end else if (pos_q >= hcfp_pkg::PAYLOAD_START && pos_q < decl_q) begin
				res_valid   = 1'b1;
				res.payload = (frame_byte == hcfp_pkg::CH_BSLASH) ?
					hcfp_pkg::CH_SPACE : frame_byte;
			end
		end else if (cmd_q == hcfp_pkg::CMD_TEST) begin
			if (comma_q) begin
				num2_d = acc_val;
			end else if (frame_byte == hcfp_pkg::CH_COMMA) begin
				comma_d = 1'b1;
			end else begin
				num1_d = acc_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			decl_q   <= '0;
			letter_q <= '0;
			cmd_q    <= hcfp_pkg::CMD_NONE;
			ferr_q   <= hcfp_pkg::ERR_OK;
			dest_q   <= '0;
			num1_q   <= '0;
			num2_q   <= '0;
			comma_q  <= 1'b0;
		end else if (step) begin
			pos_q    <= pos_d;
			decl_q   <= decl_d;
			letter_q <= letter_d;
			cmd_q    <= cmd_d;
			ferr_q   <= ferr_d;
			dest_q   <= dest_d;
			num1_q   <= num1_d;
			num2_q   <= num2_d;
			comma_q  <= comma_d;
		end
	end

endmodule

FILE: rtl/core/host_command_frame_parser_top.sv
// ---------------------------------------------------------------------------
// Host command frame parser
// Byte-wide command frame parser with payload and verdict result stream.
// ---------------------------------------------------------------------------
// Usage:
//   Frame bytes enter on s_axis (tdata = frame byte, tlast = end of frame;
//   the byte on a tlast beat is ignored). Results leave on m_axis with
//   tuser = 0 for a payload byte and 1 for the end-of-frame verdict.
//   Registers are written through cfg_we/cfg_addr/cfg_wdata while idle.
// Pipeline: a beat accepted into the input register is parsed there; its
//   result, if any, is captured in the output register when it advances.
// Throughput: one beat per cycle while the output is not stalled, set by the
//   combinational parse step between the input and output registers.
// Reset: arst_n clears the frame state, empties both stages and loads
//   the register defaults (flag 'D', peer 'P', broadcast 'B').
// Stall: while m_axis_tready is low the output register holds; beats that
//   yield no result keep flowing, and a beat with a result waits in the
//   input register, dropping s_axis_tready until the output drains.
// ---------------------------------------------------------------------------
module host_command_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] frame_byte
	input  logic        s_axis_tlast,  // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] payload_byte, [10:8] command, [13:11] error_code, [22:14] dest_code,
	// [30:23] msg_length, [46:31] group_count, [62:47] fail_delay, [63] zero
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tuser   // [0] result_kind
);

	hcfp_pkg::cfg_t cfg_q;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           end_s1;
	logic           out_valid_q;
	hcfp_pkg::res_t res_q;
	hcfp_pkg::res_t res;
	logic           res_valid;
	logic           adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.option_flag <= hcfp_pkg::OPTION_FLAG_RST;
			cfg_q.peer        <= hcfp_pkg::PEER_RST;
			cfg_q.broadcast   <= hcfp_pkg::BROADCAST_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				hcfp_pkg::CFG_OPTION_FLAG: cfg_q.option_flag <= cfg_wdata;
				hcfp_pkg::CFG_PEER:        cfg_q.peer        <= cfg_wdata;
				hcfp_pkg::CFG_BROADCAST:   cfg_q.broadcast   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv           = valid_s1 && (!res_valid || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	hcfp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.frame_byte (byte_s1),
		.frame_end  (end_s1),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {1'b0, res_q.fail_delay, res_q.group_count, res_q.msg_len,
		res_q.dest, res_q.error, res_q.command, res_q.payload};

endmodule

FILE: rtl/core/hcfp_checker.sv
// ---------------------------------------------------------------------------
// Host command frame parser port checker
// Watches the result stream of the top level; bound to every instance.
// ---------------------------------------------------------------------------
`include "host_command_frame_parser_top_macros.svh"

module hcfp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tuser
);

	`HCFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

	`HCFP_ASSERT_NOW(a_payload_clean, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:8] == 56'd0, "payload beat carries verdict fields")

	`HCFP_ASSERT_NOW(a_err_verdict, m_axis_tvalid && m_axis_tuser && m_axis_tdata[13:11] != hcfp_pkg::ERR_OK, m_axis_tdata[10:8] == hcfp_pkg::CMD_NONE && m_axis_tdata[62:14] == 49'd0, "failed verdict carries command data")

	`HCFP_ASSERT_NOW(a_send_fields, m_axis_tvalid && m_axis_tuser && m_axis_tdata[10:8] != hcfp_pkg::CMD_SEND, m_axis_tdata[30:14] == 17'd0, "destination or length outside send verdict")

	`HCFP_ASSERT_NOW(a_test_fields, m_axis_tvalid && m_axis_tuser && m_axis_tdata[10:8] != hcfp_pkg::CMD_TEST, m_axis_tdata[62:31] == 32'd0, "test numbers outside test verdict")

endmodule

bind host_command_frame_parser_top hcfp_checker u_hcfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// Host command frame parser testbench
// Streams command frames into the parser byte by byte: a short table of
// hand-picked frames first, then random SZ, TN, ZT/SC, noise, empty and
// over-long frames under several register settings. Every result beat is
// checked field by field against the bench's parser model (or a pinned
// table verdict), with random input gaps and random output back-pressure.
// ---------------------------------------------------------------------------
module tb;
	import hcfp_pkg::*;

	localparam int CYCLE_LIMIT      = 800000;
	localparam int PHASE_ITEMS      = 40;
	localparam int DRAIN_CYCLES     = 8;
	localparam int LONG_HOLD        = 500;
	localparam int SEND_MAX_PAYLOAD = 216;

	typedef enum int {
		SHAPE_SEND,
		SHAPE_SEND_MAX,
		SHAPE_TEST,
		SHAPE_FIXED,
		SHAPE_NOISE,
		SHAPE_EMPTY,
		SHAPE_LONG
	} frame_shape_t;

	typedef struct packed {
		logic        is_end;
		logic [7:0]  data;
		logic        pinned;
		cmd_t        cmd;
		err_t        err;
		logic [15:0] grp;
		logic [15:0] dly;
	} dir_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_addr      = 2'd0;
	logic [7:0]  cfg_wdata     = 8'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;

	host_command_frame_parser_top dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// parser model state
	logic [7:0]  fr_pos, fr_len, fr_lead;
	cmd_t        fr_cmd;
	err_t        fr_err;
	logic [8:0]  fr_dest;
	logic [15:0] fr_num1, fr_num2;
	logic        fr_comma;
	logic [7:0]  rg_flag, rg_peer, rg_bcast;

	res_t pending_results[$];
	res_t got, want;
	int   errors       = 0;
	int   items_sent   = 0;
	int   results_seen = 0;
	int   hold_left    = 0;
	int   cycle_count  = 0;
	bit   tx_gaps_on   = 1'b1;
	bit   rx_stalls_on = 1'b1;

	dir_row_t dir_tab [27] = '{
		'{1'b1, 8'h00,      1'b1, CMD_NONE,  ERR_LEN,     16'd0, 16'd0},
		'{1'b0, 8'h00,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b1, 8'hff,      1'b1, CMD_NONE,  ERR_LEN,     16'd0, 16'd0},
		'{1'b0, 8'd35,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_S,       1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_C,       1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b1, 8'h00,      1'b1, CMD_CHECK, ERR_OK,      16'd0, 16'd0},
		'{1'b0, 8'd34,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_Z,       1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b1, 8'h00,      1'b1, CMD_NONE,  ERR_UNKNOWN, 16'd0, 16'd0},
		'{1'b0, 8'd41,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_S,       1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_Z,       1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, OPTION_FLAG_RST, 1'b0, CMD_NONE, ERR_OK,  16'd0, 16'd0},
		'{1'b0, BROADCAST_RST,   1'b0, CMD_NONE, ERR_OK,  16'd0, 16'd0},
		'{1'b0, 8'hff,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, 8'h00,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_BSLASH,  1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, 8'hff,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b1, 8'h00,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, 8'd38,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_T,       1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_N,       1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, 8'h31,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, CH_COMMA,   1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b0, 8'h32,      1'b0, CMD_NONE,  ERR_OK,      16'd0, 16'd0},
		'{1'b1, 8'h7f,      1'b1, CMD_TEST,  ERR_OK,      16'd1, 16'd2}
	};

	function automatic void clear_frame();
		fr_pos   = 8'd0;
		fr_len   = 8'd0;
		fr_lead  = 8'd0;
		fr_cmd   = CMD_NONE;
		fr_err   = ERR_OK;
		fr_dest  = 9'd0;
		fr_num1  = 16'd0;
		fr_num2  = 16'd0;
		fr_comma = 1'b0;
	endfunction

	function automatic logic [15:0] next_decimal(input logic [15:0] v, input logic [7:0] b);
		return v * 16'd10 + {8'd0, b} - {8'd0, CH_ZERO};
	endfunction

	function automatic bit parse_beat(input logic [7:0] b, input logic is_end, output res_t r);
		err_t       e;
		logic [7:0] p;
		bit         hit;
		r   = '0;
		p   = fr_pos;
		hit = 1'b0;
		if (is_end) begin
			if (p == 8'd0 || p != fr_len) e = ERR_LEN;
			else if (fr_err != ERR_OK) e = fr_err;
			else if (fr_cmd == CMD_NONE) e = ERR_UNKNOWN;
			else if (fr_cmd == CMD_SEND && fr_len < PAYLOAD_START) e = ERR_FORMAT;
			else if (fr_cmd == CMD_TEST && !fr_comma) e = ERR_FORMAT;
			else e = ERR_OK;
			r.kind    = 1'b1;
			r.command = (e == ERR_OK) ? fr_cmd : CMD_NONE;
			r.error   = e;
			if (e == ERR_OK && fr_cmd == CMD_SEND) begin
				r.dest    = fr_dest;
				r.msg_len = fr_len - PAYLOAD_START;
			end
			if (e == ERR_OK && fr_cmd == CMD_TEST) begin
				r.group_count = fr_num1;
				r.fail_delay  = fr_num2;
			end
			clear_frame();
			return 1'b1;
		end
		if (p == 8'd0) begin
			fr_len = (b >= LEN_OFFSET) ? b - LEN_OFFSET : 8'd0;
		end else if (p == 8'd1) begin
			fr_lead = b;
		end else if (p == 8'd2) begin
			if (fr_lead == CH_S && b == CH_Z) fr_cmd = CMD_SEND;
			else if (fr_lead == CH_Z && b == CH_T) fr_cmd = CMD_ROUTE;
			else if (fr_lead == CH_S && b == CH_C) fr_cmd = CMD_CHECK;
			else if (fr_lead == CH_T && b == CH_N) fr_cmd = CMD_TEST;
			else begin
				fr_cmd = CMD_NONE;
				fr_err = ERR_UNKNOWN;
			end
		end else if (fr_cmd == CMD_SEND && fr_err == ERR_OK) begin
			if (p == 8'd3) begin
				if (b != rg_flag) fr_err = ERR_FLAG;
			end else if (p == 8'd4) begin
				if (b == rg_peer) fr_dest = DEST_PEER;
				else if (b == rg_bcast) fr_dest = DEST_BROADCAST;
				else fr_err = ERR_DIR;
			end else if (p == 8'd5) begin
				if (fr_dest == DEST_PEER) begin
					if (b >= CH_A_LOWER && b <= CH_Z_LOWER)
						fr_dest = DEST_PEER + {1'b0, b - CH_A_LOWER};
					else
						fr_err = ERR_DEST;
				end
			end else if (p >= PAYLOAD_START && p < fr_len) begin
				r.payload = (b == CH_BSLASH) ? CH_SPACE : b;
				hit       = 1'b1;
			end
		end else if (fr_cmd == CMD_TEST) begin
			if (fr_comma) fr_num2 = next_decimal(fr_num2, b);
			else if (b == CH_COMMA) fr_comma = 1'b1;
			else fr_num1 = next_decimal(fr_num1, b);
		end
		fr_pos = (p < POS_MAX) ? p + 8'd1 : POS_MAX;
		return hit;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] digit_char();
		if ($urandom_range(0, 15) == 0) return 8'($urandom);
		return 8'($urandom_range(32'(CH_ZERO), 32'(CH_ZERO) + 9));
	endfunction

	task automatic check_field(input string name, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input logic is_end, input bit pinned,
		input res_t pinned_res);
		res_t r;
		int   gap;
		gap = tx_gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_end;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		if (parse_beat(b, is_end, r)) pending_results.push_back(pinned ? pinned_res : r);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(input logic [7:0] flag_v, input logic [7:0] peer_v,
		input logic [7:0] bcast_v);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_OPTION_FLAG;
		cfg_wdata <= flag_v;
		@(posedge clk);
		cfg_addr  <= CFG_PEER;
		cfg_wdata <= peer_v;
		@(posedge clk);
		cfg_addr  <= CFG_BROADCAST;
		cfg_wdata <= bcast_v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		rg_flag  = flag_v;
		rg_peer  = peer_v;
		rg_bcast = bcast_v;
	endtask

	task automatic random_frame(input frame_shape_t shape);
		logic [7:0] body[$];
		logic [7:0] leads[5];
		logic [7:0] dir;
		int         n;
		int         r;
		bit         clean;
		leads = '{CH_S, CH_Z, CH_T, CH_C, CH_N};
		clean = (shape == SHAPE_SEND_MAX);
		body  = {};
		case (shape)
			SHAPE_SEND, SHAPE_SEND_MAX: begin
				if (clean) n = SEND_MAX_PAYLOAD;
				else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 40);
				else n = $urandom_range(0, 8);
				body = {8'h00, CH_S, CH_Z};
				body.push_back((!clean && $urandom_range(0, 11) == 0) ? 8'($urandom) : rg_flag);
				r = clean ? 7 : $urandom_range(0, 11);
				dir = (r == 0) ? 8'($urandom) : (r < 7) ? rg_peer : rg_bcast;
				body.push_back(dir);
				r = clean ? 2 : $urandom_range(0, 7);
				if (dir != rg_peer || r == 0)
					body.push_back(8'($urandom));
				else if (r == 1)
					body.push_back($urandom_range(0, 1) ? CH_A_LOWER - 8'd1 : CH_Z_LOWER + 8'd1);
				else
					body.push_back(8'($urandom_range(32'(CH_A_LOWER), 32'(CH_Z_LOWER))));
				body.push_back(8'($urandom));
				repeat (n) body.push_back(($urandom_range(0, 4) == 0) ? CH_BSLASH : 8'($urandom));
				if (!clean && $urandom_range(0, 11) == 0) begin
					n = $urandom_range(3, 6);
					while (body.size() > n) void'(body.pop_back());
				end
			end
			SHAPE_TEST: begin
				body = {8'h00, CH_T, CH_N};
				repeat ($urandom_range(0, 6)) body.push_back(digit_char());
				if ($urandom_range(0, 5) != 0) body.push_back(CH_COMMA);
				repeat ($urandom_range(0, 6)) body.push_back(digit_char());
			end
			SHAPE_FIXED: begin
				r = $urandom_range(0, 3);
				if (r == 0) body = {8'h00, CH_Z, CH_T};
				else if (r == 1) body = {8'h00, CH_S, CH_C};
				else body = {8'h00, leads[$urandom_range(0, 4)], leads[$urandom_range(0, 4)]};
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
			end
			SHAPE_NOISE: begin
				repeat ($urandom_range(1, 10)) body.push_back(8'($urandom));
			end
			SHAPE_LONG: begin
				body = {8'h00, CH_S, CH_Z, rg_flag, rg_bcast};
				repeat ($urandom_range(251, 295)) body.push_back(8'($urandom));
			end
			default: begin
			end
		endcase
		if (shape == SHAPE_NOISE || shape == SHAPE_LONG) begin
			body[0] = 8'($urandom);
		end else if (body.size() > 0) begin
			n = body.size();
			if (!clean && $urandom_range(0, 11) == 0) n = $urandom_range(0, 1) ? n + 1 : n - 1;
			body[0] = 8'(n + 32);
		end
		foreach (body[i]) send_beat(body[i], 1'b0, 1'b0, '0);
		send_beat(8'($urandom), 1'b1, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind        = m_axis_tuser;
				got.payload     = m_axis_tdata[7:0];
				got.command     = cmd_t'(m_axis_tdata[10:8]);
				got.error       = err_t'(m_axis_tdata[13:11]);
				got.dest        = m_axis_tdata[22:14];
				got.msg_len     = m_axis_tdata[30:23];
				got.group_count = m_axis_tdata[46:31];
				got.fail_delay  = m_axis_tdata[62:47];
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual tuser %0b tdata %h",
						$time, m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", 16'(want.kind), 16'(got.kind));
					check_field("payload_byte", 16'(want.payload), 16'(got.payload));
					check_field("command", 16'(want.command), 16'(got.command));
					check_field("error_code", 16'(want.error), 16'(got.error));
					check_field("dest_code", 16'(want.dest), 16'(got.dest));
					check_field("msg_length", 16'(want.msg_len), 16'(got.msg_len));
					check_field("group_count", want.group_count, got.group_count);
					check_field("fail_delay", want.fail_delay, got.fail_delay);
				end
				results_seen++;
				if (results_seen % 400 == 40) hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				hold_left = idle_len();
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		res_t         pin;
		int           target;
		int           r;
		logic [7:0]   shared;
		frame_shape_t shape;
		clear_frame();
		rg_flag  = OPTION_FLAG_RST;
		rg_peer  = PEER_RST;
		rg_bcast = BROADCAST_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			pin             = '0;
			pin.kind        = 1'b1;
			pin.command     = dir_tab[i].cmd;
			pin.error       = dir_tab[i].err;
			pin.group_count = dir_tab[i].grp;
			pin.fail_delay  = dir_tab[i].dly;
			send_beat(dir_tab[i].data, dir_tab[i].is_end, dir_tab[i].pinned, pin);
		end
		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: load_regs(OPTION_FLAG_RST, PEER_RST, BROADCAST_RST);
				1: load_regs(8'($urandom), 8'($urandom), 8'($urandom));
				2: load_regs(8'h00, 8'hff, 8'h00);
				3: load_regs(8'hff, 8'h00, 8'hff);
				default: begin
					shared = 8'($urandom);
					load_regs(8'($urandom), shared, shared);
				end
			endcase
			if (ph == 1) random_frame(SHAPE_LONG);
			if (ph == 2) random_frame(SHAPE_SEND_MAX);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				tx_gaps_on   = ($urandom_range(0, 4) != 0);
				rx_stalls_on = ($urandom_range(0, 4) != 0);
				r = $urandom_range(0, 99);
				shape = (r < 45) ? SHAPE_SEND : (r < 70) ? SHAPE_TEST :
					(r < 82) ? SHAPE_FIXED : (r < 95) ? SHAPE_NOISE : SHAPE_EMPTY;
				random_frame(shape);
			end
		end
		settle();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
